>>> sv/iwf_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// iwf_pkg: shared definitions for the warm-up gated IIR filter
// Tap counts, fixed-point widths, register indexes and the sequencer states.
// ---------------------------------------------------------------------------
package iwf_pkg;

	// Filter order: feedforward and feedback tap counts.
	localparam int NUM_B = 4;
	localparam int NUM_A = 4;

	// Payload widths.
	localparam int TIME_W   = 32;
	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 18;

	// Coefficient register file.
	localparam int NUM_REGS  = 8;
	localparam int REG_IDX_W = $clog2(NUM_REGS);
	localparam logic [REG_IDX_W-1:0] REG_B0 = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_A1 = REG_IDX_W'(4);
	localparam logic signed [COEF_W-1:0] COEF_B0_RESET = COEF_W'(32768);

	// Product is Q4.30; the accumulator holds up to eight products exactly.
	localparam int PROD_W = COEF_W + SAMPLE_W;
	localparam int ACC_W  = PROD_W + 4;
	localparam int FRAC_W = 15;
	localparam int Q_W    = ACC_W - FRAC_W;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_DONE
	} state_t;

endpackage

>>> sv/iwf_in_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// iwf_in_if: input sample channel
// Valid/ready channel carrying a timestamp and a Q1.15 sample.
// ---------------------------------------------------------------------------
interface iwf_in_if
	import iwf_pkg::*;
();
	logic                       valid;
	logic                       ready;
	logic [TIME_W-1:0]          in_time;
	logic signed [SAMPLE_W-1:0] sample;

	modport source (output valid, output in_time, output sample, input ready);
	modport sink (input valid, input in_time, input sample, output ready);
endinterface

>>> sv/iwf_out_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// iwf_out_if: filtered result channel
// Valid/ready channel carrying the passed-through timestamp and the result.
// ---------------------------------------------------------------------------
interface iwf_out_if
	import iwf_pkg::*;
();
	logic                       valid;
	logic                       ready;
	logic [TIME_W-1:0]          out_time;
	logic signed [SAMPLE_W-1:0] filtered;

	modport source (output valid, output out_time, output filtered, input ready);
	modport sink (input valid, input out_time, input filtered, output ready);
endinterface

>>> sv/iir_filter_step_with_warmup_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// iir_filter_step_with_warmup_core: direct-form-I IIR filter with warm-up
// Samples arrive on in_ch and results leave on out_ch, both valid/ready.
// One shared 18x16 multiplier and an exact accumulator are stepped over the
// taps by a small sequencer.
//
// Usage:
// - Coefficients are written through cfg_we/cfg_index/cfg_data; the user must
//   do so only while idle (not enforced). After reset b0 is 1.0, others zero.
// - The first NUM_B-1 samples only fill the input history; each such
//   transfer leaves the sequencer idle and produces no result.
// - Every later sample produces one result. The sequencer runs one tap per
//   cycle through the multiplier: NUM_B feedforward taps plus one feedback
//   tap for each output produced so far (at most NUM_A), then a drain step
//   for the product register and a final step that rounds and saturates.
// - in_ch.ready is high only while the sequencer is idle.
// - Results sit in an output register. A stalled receiver holds that
//   register; the next item is still taken and computed, and waits in the
//   final step until the output register is free.
// - Reset clears the fill counts, the output valid flag and all taps but b0.
// ---------------------------------------------------------------------------
module iir_filter_step_with_warmup_core
	import iwf_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	iwf_in_if.sink                     in_ch,
	iwf_out_if.source                  out_ch,
	input  logic                       cfg_we,
	input  logic [REG_IDX_W-1:0]       cfg_index,
	input  logic signed [COEF_W-1:0]   cfg_data
);

	localparam int YH_DEPTH = (NUM_A > 0) ? NUM_A : 1;
	localparam int XH_IW    = (NUM_B > 1) ? $clog2(NUM_B) : 1;
	localparam int YH_IW    = (YH_DEPTH > 1) ? $clog2(YH_DEPTH) : 1;
	localparam int TAP_W    = $clog2(NUM_B + NUM_A + 1);
	localparam int FILL_W   = 3;

	state_t state_q, state_d;

	logic signed [COEF_W-1:0]   coef_q [NUM_REGS];
	logic signed [SAMPLE_W-1:0] xh_q [NUM_B];
	logic signed [SAMPLE_W-1:0] yh_q [YH_DEPTH];
	logic [FILL_W-1:0]          x_fill_q;
	logic [FILL_W-1:0]          y_fill_q;
	logic [TIME_W-1:0]          time_q;
	logic [TAP_W-1:0]           tap_q;
	logic [TAP_W-1:0]           tap_end_q;

	logic signed [PROD_W-1:0]   prod_s1;
	logic                       sub_s1;
	logic                       pvld_s1;
	logic signed [ACC_W-1:0]    acc_q;

	logic                       out_valid_q;
	logic [TIME_W-1:0]          out_time_q;
	logic signed [SAMPLE_W-1:0] out_filt_q;

	logic                       in_xfer;
	logic                       out_xfer;
	logic                       in_ready;
	logic                       mac_en;
	logic                       done_fire;
	logic                       tap_last;
	logic                       warm_done;
	logic [FILL_W-1:0]          x_fill_inc;

	// Transfer strobes.
	assign in_xfer  = in_ch.valid && in_ready;
	assign out_xfer = out_valid_q && out_ch.ready;
	assign in_ch.ready = in_ready;

	// Input history fill after this sample is written.
	assign x_fill_inc = (x_fill_q < FILL_W'(NUM_B)) ? x_fill_q + FILL_W'(1) : x_fill_q;
	assign warm_done  = (x_fill_inc >= FILL_W'(NUM_B));
	assign tap_last   = (tap_q == tap_end_q - TAP_W'(1));

	// Next-state logic of the sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_ch.valid && warm_done) begin
					state_d = ST_MAC;
				end
			end
			ST_MAC: begin
				if (tap_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ch.ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Output decode of the sequencer.
	always_comb begin
		in_ready  = 1'b0;
		mac_en    = 1'b0;
		done_fire = 1'b0;
		unique case (state_q)
			ST_IDLE:  in_ready  = 1'b1;
			ST_MAC:   mac_en    = 1'b1;
			ST_DRAIN: done_fire = 1'b0;
			ST_DONE:  done_fire = !out_valid_q || out_ch.ready;
			default:  in_ready  = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Coefficient registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				coef_q[i] <= (i == int'(REG_B0)) ? COEF_B0_RESET : COEF_W'(0);
			end
		end else if (cfg_we) begin
			coef_q[cfg_index] <= cfg_data;
		end
	end

	// Input history shift line, newest sample at the head, and its fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_fill_q <= '0;
		end else if (in_xfer) begin
			x_fill_q <= x_fill_inc;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			xh_q[0] <= in_ch.sample;
			for (int i = 1; i < NUM_B; i++) begin
				xh_q[i] <= xh_q[i-1];
			end
			time_q <= in_ch.in_time;
		end
	end

	// Tap counter: feedforward taps first, then one per stored output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q     <= '0;
			tap_end_q <= '0;
		end else if (in_xfer) begin
			tap_q     <= '0;
			tap_end_q <= TAP_W'(NUM_B) + TAP_W'(y_fill_q);
		end else if (mac_en) begin
			tap_q <= tap_q + TAP_W'(1);
		end
	end

	// Operand selection for the shared multiplier.
	logic [TAP_W-1:0]           ytap;
	logic                       fb_tap;
	logic [REG_IDX_W-1:0]       coef_idx;
	logic signed [COEF_W-1:0]   mul_a;
	logic signed [SAMPLE_W-1:0] mul_b;
	logic signed [PROD_W-1:0]   prod_c;

	assign ytap   = tap_q - TAP_W'(NUM_B);
	assign fb_tap = (tap_q >= TAP_W'(NUM_B));

	always_comb begin
		if (fb_tap) begin
			coef_idx = REG_IDX_W'(ytap) + REG_A1;
			mul_b    = yh_q[ytap[YH_IW-1:0]];
		end else begin
			coef_idx = REG_IDX_W'(tap_q);
			mul_b    = xh_q[tap_q[XH_IW-1:0]];
		end
	end

	assign mul_a  = coef_q[coef_idx];
	assign prod_c = mul_a * mul_b;

	// Product register between multiplier and accumulator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pvld_s1 <= 1'b0;
		end else begin
			pvld_s1 <= mac_en;
		end
	end

	always_ff @(posedge clk) begin
		if (mac_en) begin
			prod_s1 <= prod_c;
			sub_s1  <= fb_tap;
		end
	end

	// Exact accumulator: feedback products are subtracted.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			acc_q <= '0;
		end else if (pvld_s1) begin
			if (sub_s1) begin
				acc_q <= acc_q - ACC_W'(prod_s1);
			end else begin
				acc_q <= acc_q + ACC_W'(prod_s1);
			end
		end
	end

	// Round to nearest with ties upwards, then saturate to Q1.15.
	localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(32767);
	localparam logic signed [Q_W-1:0] Q_MIN = -Q_W'(32768);

	logic signed [ACC_W-1:0]    rnd_v;
	logic signed [Q_W-1:0]      rnd_q;
	logic signed [SAMPLE_W-1:0] y_sat;

	assign rnd_v = acc_q + ACC_W'(1 << (FRAC_W - 1));
	assign rnd_q = rnd_v[ACC_W-1:FRAC_W];

	always_comb begin
		if (rnd_q > Q_MAX) begin
			y_sat = SAMPLE_W'(Q_MAX);
		end else if (rnd_q < Q_MIN) begin
			y_sat = SAMPLE_W'(Q_MIN);
		end else begin
			y_sat = rnd_q[SAMPLE_W-1:0];
		end
	end

	// Output history shift line, newest output at the head.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			y_fill_q <= '0;
		end else if (done_fire && (NUM_A > 0) && (y_fill_q < FILL_W'(NUM_A))) begin
			y_fill_q <= y_fill_q + FILL_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (done_fire) begin
			yh_q[0] <= y_sat;
			for (int i = 1; i < YH_DEPTH; i++) begin
				yh_q[i] <= yh_q[i-1];
			end
		end
	end

	// Output register towards the receiver.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_fire) begin
			out_time_q <= time_q;
			out_filt_q <= y_sat;
		end
	end

	assign out_ch.valid    = out_valid_q;
	assign out_ch.out_time = out_time_q;
	assign out_ch.filtered = out_filt_q;

	// A new result appears only from the final step of the sequencer.
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result appeared outside the final step");

	// The tap counter stays within the taps set up for this item.
	a_tap_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAC) |-> (tap_q < tap_end_q))
		else $error("tap counter ran past the last tap");

	// A warm-up sample produces no work for the multiplier.
	a_warmup_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && !warm_done) |=> (state_q == ST_IDLE))
		else $error("warm-up sample started the multiplier");

	// Fill counts never exceed their history depths.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(x_fill_q <= FILL_W'(NUM_B)) && (y_fill_q <= FILL_W'(NUM_A)))
		else $error("history fill count out of range");

endmodule

>>> dv/iwf_result_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// iwf_result_checker: result prediction and comparison for the IIR core
// Watches the sample, result and coefficient ports, keeps its own copy of
// the taps and both history rings, predicts each result from the accepted
// samples and compares every result transfer with the oldest prediction.
// ---------------------------------------------------------------------------
module iwf_result_checker
	import iwf_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	iwf_in_if                        in_ch,
	iwf_out_if                       out_ch,
	input  logic                     cfg_we,
	input  logic [REG_IDX_W-1:0]     cfg_index,
	input  logic signed [COEF_W-1:0] cfg_data,
	output int                       mismatches,
	output int                       results_pending
);

	localparam int     MAX_PRINTED = 40;
	localparam longint OUT_MAX     = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
	localparam longint OUT_MIN     = -(64'sd1 <<< (SAMPLE_W - 1));
	localparam longint ROUND_HALF  = 64'sd1 <<< (FRAC_W - 1);

	typedef struct packed {
		logic [TIME_W-1:0]          stamp;
		logic signed [SAMPLE_W-1:0] value;
	} filt_result_t;

	// Shadow copy of the coefficient file and of the two history rings.
	logic signed [COEF_W-1:0]   tap_coef [NUM_REGS];
	logic signed [SAMPLE_W-1:0] sample_ring [NUM_B];
	logic signed [SAMPLE_W-1:0] output_ring [NUM_A];
	int sample_wr;
	int sample_count;
	int output_wr;
	int output_count;

	filt_result_t expected_results [$];
	int n_fail = 0;

	assign mismatches = n_fail;

	// Prints one line per mismatch, up to a cap, and counts every one.
	task automatic report_mismatch(input string what);
		if (n_fail < MAX_PRINTED)
			$display("[%0t] mismatch: %s", $time, what);
		n_fail++;
	endtask

	// Takes one accepted sample into the history and, once the warm-up is
	// over, queues the filter output that it must produce.
	task automatic filter_sample(input logic [TIME_W-1:0] stamp,
			input logic signed [SAMPLE_W-1:0] x);
		longint acc;
		longint q;
		int k;
		int newest;
		int fb_taps;
		filt_result_t r;
		newest = sample_wr;
		sample_ring[newest] = x;
		sample_wr = (newest + 1) % NUM_B;
		if (sample_count < NUM_B)
			sample_count++;
		// Warm-up: the input ring is not yet full, so nothing comes out.
		if (sample_count < NUM_B)
			return;

		acc = 0;
		for (k = 0; k < NUM_B; k++)
			acc += longint'(tap_coef[int'(REG_B0) + k]) *
				longint'(sample_ring[(newest + NUM_B - k) % NUM_B]);

		// Only outputs actually produced so far take part in the feedback.
		fb_taps = (output_count < NUM_A) ? output_count : NUM_A;
		for (k = 0; k < fb_taps; k++)
			acc -= longint'(tap_coef[int'(REG_A1) + k]) *
				longint'(output_ring[(output_wr + NUM_A - 1 - k) % NUM_A]);

		// Round to nearest with ties upward, then clamp to Q1.15.
		q = (acc + ROUND_HALF) >>> FRAC_W;
		if (q > OUT_MAX)
			q = OUT_MAX;
		else if (q < OUT_MIN)
			q = OUT_MIN;

		r.stamp = stamp;
		r.value = q[SAMPLE_W-1:0];
		output_ring[output_wr] = r.value;
		output_wr = (output_wr + 1) % NUM_A;
		if (output_count < NUM_A)
			output_count++;
		expected_results = {expected_results, r};
	endtask

	// Results are checked before the sample of the same edge is predicted;
	// a sample can never produce its result in the cycle it is taken.
	always @(posedge clk or negedge arst_n) begin : monitor
		filt_result_t got;
		filt_result_t want;
		if (!arst_n) begin
			foreach (tap_coef[i])
				tap_coef[i] = '0;
			tap_coef[REG_B0] = COEF_B0_RESET;
			foreach (sample_ring[i])
				sample_ring[i] = '0;
			foreach (output_ring[i])
				output_ring[i] = '0;
			sample_wr = 0;
			sample_count = 0;
			output_wr = 0;
			output_count = 0;
			expected_results.delete();
			results_pending <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				got.stamp = out_ch.out_time;
				got.value = out_ch.filtered;
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result time %h value %0d",
						got.stamp, got.value));
				end else begin
					want = expected_results.pop_front();
					if (got.stamp !== want.stamp)
						report_mismatch($sformatf("out_time %h, predicted %h",
							got.stamp, want.stamp));
					if (got.value !== want.value)
						report_mismatch($sformatf("filtered %0d, predicted %0d (time %h)",
							got.value, want.value, want.stamp));
				end
			end
			if (in_ch.valid && in_ch.ready)
				filter_sample(in_ch.in_time, in_ch.sample);
			if (cfg_we)
				tap_coef[cfg_index] = cfg_data;
			results_pending <= expected_results.size();
		end
	end

endmodule

>>> dv/tb_iir_filter_step_with_warmup_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_iir_filter_step_with_warmup_core: stimulus and verdict for the IIR core
// Drives samples in bursts with random gaps against a receiver that stalls
// on its own pattern, reprogrammes the taps between phases while the core is
// idle, and leaves prediction and comparison to the result checker.
// ---------------------------------------------------------------------------
module tb_iir_filter_step_with_warmup_core;
	import iwf_pkg::*;

	// Slowest correct run: about 720 items, each with a full filter step, the
	// longest receiver stall and sender gap, plus the idle pauses between
	// phases; the limit is several times that.
	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_PHASES = 7;
	localparam int PHASE_ITEMS   = 100;
	localparam int DRAIN_CYCLES  = 16;

	localparam logic signed [COEF_W-1:0]   COEF_MAX   = 18'sh1FFFF;
	localparam logic signed [COEF_W-1:0]   COEF_MIN   = 18'sh20000;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_RANDOM,
		RX_HOLD,
		RX_TOGGLE
	} rx_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [REG_IDX_W-1:0] cfg_index;
	logic signed [COEF_W-1:0] cfg_data;
	logic sink_ready = 1'b0;

	int mismatches;
	int results_pending;
	int cycle_count = 0;

	logic signed [COEF_W-1:0] taps [NUM_REGS];
	logic [TIME_W-1:0] stamp_seq;
	int burst_left;
	rx_mode_t rx_mode = RX_OPEN;
	int rx_left = 0;

	iwf_in_if  in_ch ();
	iwf_out_if out_ch ();

	assign out_ch.ready = sink_ready;

	iir_filter_step_with_warmup_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	iwf_result_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_ch           (in_ch),
		.out_ch          (out_ch),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mismatches      (mismatches),
		.results_pending (results_pending)
	);

	// 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("iir_filter_step_with_warmup_core verification failed");
			$finish;
		end
	end

	// Receiver: segments of random length, each open, random, held or toggling.
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(1, 40);
		end
		rx_left--;
		case (rx_mode)
			RX_OPEN: begin
				sink_ready <= 1'b1;
			end
			RX_RANDOM: begin
				sink_ready <= 1'($urandom_range(0, 1));
			end
			RX_HOLD: begin
				sink_ready <= 1'b0;
			end
			default: begin
				sink_ready <= ~sink_ready;
			end
		endcase
	end

	// Presents one sample and returns at the edge of its transfer, with
	// valid still high so that a following sample can go straight on.
	task automatic send_sample(input logic [TIME_W-1:0] stamp,
			input logic signed [SAMPLE_W-1:0] value);
		in_ch.valid   <= 1'b1;
		in_ch.in_time <= stamp;
		in_ch.sample  <= value;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
	endtask

	// Stops the sender and waits until every predicted result has left,
	// then gives any warm-up sample still in the core time to finish.
	task automatic settle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (results_pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	// Writes registers first..last from the taps array once the core is idle.
	task automatic program_taps(input int first, input int last);
		int i;
		settle();
		for (i = first; i <= last; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= REG_IDX_W'(i);
			cfg_data  <= taps[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// Random coefficient: extremes and full range in wild phases, otherwise
	// moderate values, with small feedback taps so that the output stays lively.
	function automatic logic signed [COEF_W-1:0] draw_coef(input bit wild,
			input bit feedback);
		int pick;
		pick = $urandom_range(0, 9);
		if (wild && pick == 0)
			return COEF_MIN;
		if (wild && pick == 1)
			return COEF_MAX;
		if (pick == 2)
			return '0;
		if (wild && pick < 6)
			return COEF_W'($urandom());
		if (feedback)
			return COEF_W'(int'($urandom_range(0, 8192)) - 4096);
		return COEF_W'(int'($urandom_range(0, 65536)) - 32768);
	endfunction

	// One random phase: new taps, then samples in bursts with random gaps.
	task automatic run_random_phase(input bit wild);
		int i;
		logic signed [SAMPLE_W-1:0] value;
		for (i = 0; i < NUM_REGS; i++)
			taps[i] = draw_coef(wild, i >= int'(REG_A1));
		program_taps(0, NUM_REGS - 1);
		burst_left = 0;
		for (i = 0; i < PHASE_ITEMS; i++) begin
			if (burst_left == 0) begin
				in_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 15))
					@(posedge clk);
				burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) :
					$urandom_range(1, 12);
			end
			burst_left--;
			case ($urandom_range(0, 7))
				0: value = SAMPLE_MAX;
				1: value = SAMPLE_MIN;
				2: value = SAMPLE_W'(int'($urandom_range(0, 128)) - 64);
				default: value = SAMPLE_W'($urandom());
			endcase
			stamp_seq = ($urandom_range(0, 3) == 0) ? TIME_W'($urandom()) : stamp_seq + 1;
			send_sample(stamp_seq, value);
		end
	endtask

	initial begin
		int i;
		in_ch.valid   <= 1'b0;
		in_ch.in_time <= '0;
		in_ch.sample  <= '0;
		cfg_we        <= 1'b0;
		cfg_index     <= '0;
		cfg_data      <= '0;
		stamp_seq = '0;

		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Only the feedback taps are written: the feedforward taps keep their
		// reset values, and the feedback grows as outputs are produced.
		taps[int'(REG_A1)]     = -18'sd16384;
		taps[int'(REG_A1) + 1] = 18'sd8192;
		taps[int'(REG_A1) + 2] = -18'sd4096;
		taps[int'(REG_A1) + 3] = 18'sd2048;
		program_taps(int'(REG_A1), NUM_REGS - 1);

		// Warm-up: the first three samples give nothing; then both saturations.
		send_sample('0, SAMPLE_MAX);
		send_sample('1, SAMPLE_MIN);
		send_sample($urandom(), 16'sd0);
		send_sample($urandom(), -16'sd1);
		send_sample($urandom(), 16'sd1);
		send_sample($urandom(), SAMPLE_MAX);
		send_sample($urandom(), SAMPLE_MAX);
		send_sample($urandom(), SAMPLE_MAX);
		send_sample($urandom(), SAMPLE_MIN);
		send_sample($urandom(), SAMPLE_MIN);

		// Half-way rounding: b0 of one half gives exact ties in both signs.
		for (i = 0; i < NUM_REGS; i++)
			taps[i] = '0;
		taps[REG_B0] = 18'sd16384;
		program_taps(0, NUM_REGS - 1);
		send_sample($urandom(), 16'sd1);
		send_sample($urandom(), -16'sd1);
		send_sample($urandom(), 16'sd3);
		send_sample($urandom(), -16'sd3);

		// Extreme taps with extreme samples, in both sign arrangements.
		for (i = 0; i < NUM_REGS; i++)
			taps[i] = (i < int'(REG_A1)) ? COEF_MIN : COEF_MAX;
		program_taps(0, NUM_REGS - 1);
		send_sample($urandom(), SAMPLE_MIN);
		send_sample($urandom(), SAMPLE_MAX);
		send_sample($urandom(), SAMPLE_MIN);
		send_sample($urandom(), SAMPLE_MAX);

		for (i = 0; i < NUM_REGS; i++)
			taps[i] = (i < int'(REG_A1)) ? COEF_MAX : COEF_MIN;
		program_taps(0, NUM_REGS - 1);
		send_sample($urandom(), SAMPLE_MAX);
		send_sample($urandom(), SAMPLE_MAX);
		send_sample($urandom(), SAMPLE_MIN);
		send_sample($urandom(), SAMPLE_MIN);

		// Random phases, alternating moderate and wild tap settings.
		for (i = 0; i < RANDOM_PHASES; i++)
			run_random_phase(i[0]);

		settle();
		if (mismatches == 0 && results_pending == 0)
			$display("iir_filter_step_with_warmup_core verification clean");
		else
			$display("iir_filter_step_with_warmup_core verification failed");
		$finish;
	end

endmodule

>>> filelist.f
sv/iwf_pkg.sv
sv/iwf_in_if.sv
sv/iwf_out_if.sv
sv/iir_filter_step_with_warmup_core.sv
dv/iwf_result_checker.sv
dv/tb_iir_filter_step_with_warmup_core.sv
